// File: rtl/cscan_pkg.sv
`default_nettype none

package cscan_pkg;

   localparam int MAX_REQUESTS_DEF = 32;

   localparam int CYL_W   = 16;
   localparam int DISK_W  = 17;
   localparam int TOTAL_W = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic [TOTAL_W-1:0] MOVE_MAX = {TOTAL_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_CYLINDERS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_RIGHT    = 2'd2;

   localparam logic [DISK_W-1:0] DISK_CYLINDERS_RST = 17'd200;
   localparam logic [CYL_W-1:0]  START_HEAD_RST     = 16'd0;
   localparam logic              SWEEP_RIGHT_RST    = 1'b1;

   typedef struct packed {
      logic [DISK_W-1:0] disk_cylinders;
      logic [CYL_W-1:0]  start_head;
      logic              sweep_right;
   } cfg_type;

   typedef struct packed {
      logic load;     // accept one request beat into the sorted row
      logic init;     // start of scheduling: head, total and staging reset
      logic scan;     // rotate the row by one and serve the cell at its end
      logic phase_c;  // second pass over the row, after the jump
      logic end1;     // visit the disk end reached first
      logic end2;     // jump to the other disk end
      logic flush;    // send the staged visit as the final result
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/cscan_disk_scheduler_top.sv
`default_nettype none

// Requests load one per cycle while busy is low; each beat is insertion-sorted on arrival.
// After the last request, scheduling runs two full rotations of the sorted row, two
// disk-end steps and one final flush; results appear during it.
// Synchronous active-high reset clears the batch and returns the configuration registers
// to their defaults. Results cannot be stalled by the receiver.
module cscan_disk_scheduler_top
   import cscan_pkg::*;
#(
   parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CYL_W-1:0]     req_cylinder,
   input  wire logic                 req_last_request,
   output logic                      rsp_strobe,
   output logic [CYL_W-1:0]          rsp_visit_cylinder,
   output logic [TOTAL_W-1:0]        rsp_total_movement,
   output logic                      rsp_dropped,
   output logic                      rsp_last_visit,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DISK_W-1:0]    csr_data
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DISK_CYLINDERS: cfg_in.disk_cylinders = csr_data;
            CSR_START_HEAD:     cfg_in.start_head     = csr_data[CYL_W-1:0];
            CSR_SWEEP_RIGHT:    cfg_in.sweep_right    = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_cylinders <= DISK_CYLINDERS_RST;
         cfg_ff.start_head     <= START_HEAD_RST;
         cfg_ff.sweep_right    <= SWEEP_RIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cscan_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_last_request (req_last_request),
      .status           (status),
      .busy             (busy),
      .cmd              (cmd)
   );

   cscan_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .req_cylinder       (req_cylinder),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_visit_cylinder (rsp_visit_cylinder),
      .rsp_total_movement (rsp_total_movement),
      .rsp_dropped        (rsp_dropped),
      .rsp_last_visit     (rsp_last_visit)
   );

endmodule

`default_nettype wire

// File: rtl/cscan_ctrl.sv
`default_nettype none

module cscan_ctrl
   import cscan_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       req_last_request,
   input  wire status_type status,
   output logic            busy,
   output cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN_A = 6'b000010,
      S_END1   = 6'b000100,
      S_END2   = 6'b001000,
      S_SCAN_C = 6'b010000,
      S_FLUSH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_last_request) begin
                  cmd.init = 1'b1;
                  state_in = S_SCAN_A;
               end
            end
         end
         S_SCAN_A: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_END1;
            end
         end
         S_END1: begin
            cmd.end1 = 1'b1;
            state_in = S_END2;
         end
         S_END2: begin
            cmd.end2 = 1'b1;
            state_in = S_SCAN_C;
         end
         S_SCAN_C: begin
            cmd.scan    = 1'b1;
            cmd.phase_c = 1'b1;
            if (status.scan_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/cscan_datapath.sv
`default_nettype none

module cscan_datapath
   import cscan_pkg::*;
#(
   parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire cmd_type            cmd,
   input  wire logic [CYL_W-1:0]   req_cylinder,
   output status_type              status,
   output logic                    rsp_strobe,
   output logic [CYL_W-1:0]        rsp_visit_cylinder,
   output logic [TOTAL_W-1:0]      rsp_total_movement,
   output logic                    rsp_dropped,
   output logic                    rsp_last_visit
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REQUESTS);

   // Sorted row: entries 0 .. count-1 hold the batch in ascending order.
   logic [CYL_W-1:0]   cells_ff [MAX_REQUESTS];
   logic [CYL_W-1:0]   cells_in [MAX_REQUESTS];
   logic               gt       [MAX_REQUESTS];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [CYL_W-1:0]   pos_ff, pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CYL_W-1:0]   pend_cyl_ff, pend_cyl_in;
   logic               out_strobe_ff, out_strobe_in;
   logic [CYL_W-1:0]   out_cyl_ff, out_cyl_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic               out_dropped_ff, out_dropped_in;
   logic               out_last_ff, out_last_in;

   logic               room;
   logic               right;
   logic [CYL_W-1:0]   top;
   logic [IDX_W-1:0]   logical_idx;
   logic               in_batch;
   logic [CYL_W-1:0]   end_cell;
   logic               above;
   logic               visit;
   logic [CYL_W-1:0]   visit_cyl;
   logic [CYL_W-1:0]   delta;
   logic [TOTAL_W:0]   sum;

   assign room  = (count_ff < FULL_CNT);
   assign right = cfg.sweep_right;

   always_comb begin
      if (cfg.disk_cylinders == '0) begin
         top = '0;
      end else if (cfg.disk_cylinders > DISK_W'(17'h10000)) begin
         top = '1;
      end else begin
         top = CYL_W'(cfg.disk_cylinders - DISK_W'(1));
      end
   end

   // Invalid cells count as greater, so a value no held cell exceeds lands right after the batch.
   generate
      for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
         assign gt[g] = (CNT_W'(g) >= count_ff) || (cells_ff[g] > req_cylinder);

         always_comb begin
            cells_in[g] = cells_ff[g];
            if (cmd.load && room) begin
               if (g > 0 && gt[(g > 0) ? g - 1 : 0]) begin
                  cells_in[g] = cells_ff[(g > 0) ? g - 1 : 0];
               end else if (gt[g]) begin
                  cells_in[g] = req_cylinder;
               end
            end else if (cmd.scan) begin
               if (right) begin
                  cells_in[g] = cells_ff[(g + 1) % MAX_REQUESTS];
               end else begin
                  cells_in[g] = cells_ff[(g + MAX_REQUESTS - 1) % MAX_REQUESTS];
               end
            end
         end

         always_ff @(posedge clock) begin
            cells_ff[g] <= cells_in[g];
         end
      end
   endgenerate

   // The row rotates once per scan beat; k tracks which sorted entry sits at the end.
   assign logical_idx = right ? k_ff : (LAST_IDX - k_ff);
   assign in_batch    = (CNT_W'(logical_idx) < count_ff);
   assign end_cell    = right ? cells_ff[0] : cells_ff[MAX_REQUESTS-1];
   assign above       = (end_cell > cfg.start_head);
   assign status.scan_done = (k_ff == LAST_IDX);

   always_comb begin
      visit     = 1'b0;
      visit_cyl = end_cell;
      if (cmd.scan) begin
         visit = in_batch && (above == (right ^ cmd.phase_c));
      end else if (cmd.end1) begin
         visit     = 1'b1;
         visit_cyl = right ? top : '0;
      end else if (cmd.end2) begin
         visit     = 1'b1;
         visit_cyl = right ? '0 : top;
      end
   end

   always_comb begin
      if (cmd.end2) begin
         delta = top;
      end else if (visit_cyl >= pos_ff) begin
         delta = visit_cyl - pos_ff;
      end else begin
         delta = pos_ff - visit_cyl;
      end
      sum = {1'b0, total_ff} + (TOTAL_W + 1)'(delta);
   end

   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      k_in           = k_ff;
      pos_in         = pos_ff;
      total_in       = total_ff;
      pend_valid_in  = pend_valid_ff;
      pend_cyl_in    = pend_cyl_ff;
      out_strobe_in  = 1'b0;
      out_cyl_in     = out_cyl_ff;
      out_total_in   = out_total_ff;
      out_dropped_in = out_dropped_ff;
      out_last_in    = out_last_ff;

      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.init) begin
         k_in          = '0;
         pos_in        = cfg.start_head;
         total_in      = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.scan) begin
         k_in = status.scan_done ? '0 : k_ff + IDX_W'(1);
      end

      // Visits pass through a one-deep stage so that the final one can be marked.
      if (visit) begin
         pos_in        = visit_cyl;
         total_in      = (sum > (TOTAL_W + 1)'(MOVE_MAX)) ? MOVE_MAX : sum[TOTAL_W-1:0];
         pend_valid_in = 1'b1;
         pend_cyl_in   = visit_cyl;
         if (pend_valid_ff) begin
            out_strobe_in  = 1'b1;
            out_cyl_in     = pend_cyl_ff;
            out_total_in   = '0;
            out_dropped_in = overflow_ff;
            out_last_in    = 1'b0;
         end
      end

      if (cmd.flush) begin
         out_strobe_in  = 1'b1;
         out_cyl_in     = pend_cyl_ff;
         out_total_in   = total_ff;
         out_dropped_in = overflow_ff;
         out_last_in    = 1'b1;
         pend_valid_in  = 1'b0;
         count_in       = '0;
         overflow_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      total_ff       <= total_in;
      pend_cyl_ff    <= pend_cyl_in;
      out_cyl_ff     <= out_cyl_in;
      out_total_ff   <= out_total_in;
      out_dropped_ff <= out_dropped_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_strobe         = out_strobe_ff;
   assign rsp_visit_cylinder = out_cyl_ff;
   assign rsp_total_movement = out_total_ff;
   assign rsp_dropped        = out_dropped_ff;
   assign rsp_last_visit     = out_last_ff;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cscan_pkg::*;

   localparam int MAX_REQ = MAX_REQUESTS_DEF;
   // Scheduling takes two rotations of the sorted row plus the disk-end steps and the flush.
   localparam int LINGER = 2 * MAX_REQ + 3;
   localparam int ITEM_TARGET = 350;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [CYL_W-1:0]   cylinder;
      logic [TOTAL_W-1:0] movement;
      logic               dropped;
      logic               final_visit;
   } visit_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CYL_W-1:0]     req_cylinder = '0;
   logic                 req_last_request = 1'b0;
   logic                 rsp_strobe;
   logic [CYL_W-1:0]     rsp_visit_cylinder;
   logic [TOTAL_W-1:0]   rsp_total_movement;
   logic                 rsp_dropped;
   logic                 rsp_last_visit;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DISK_W-1:0]    csr_data = '0;

   cscan_disk_scheduler_top #(.MAX_REQUESTS(MAX_REQ)) DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cylinder       (req_cylinder),
      .req_last_request   (req_last_request),
      .rsp_strobe         (rsp_strobe),
      .rsp_visit_cylinder (rsp_visit_cylinder),
      .rsp_total_movement (rsp_total_movement),
      .rsp_dropped        (rsp_dropped),
      .rsp_last_visit     (rsp_last_visit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Shadow of the scheduler: registers, held requests and the visits still to come.
   cfg_type          geometry = '{DISK_CYLINDERS_RST, START_HEAD_RST, SWEEP_RIGHT_RST};
   logic [CYL_W-1:0] held [MAX_REQ];
   int               held_count = 0;
   logic             overflow = 1'b0;
   visit_type        pending_visits [$];
   visit_type        due_visit;
   int               error_count = 0;
   int               items_sent = 0;
   bit               steady = 1'b0;

   function automatic int unsigned top_of(logic [DISK_W-1:0] disk);
      int unsigned top;
      top = (disk == 0) ? 0 : disk - 1;
      return (top > 65535) ? 65535 : top;
   endfunction

   function automatic int unsigned travel(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int unsigned add_travel(int unsigned acc, int unsigned d);
      int unsigned sum;
      sum = acc + d;
      return (sum > MOVE_MAX) ? MOVE_MAX : sum;
   endfunction

   function automatic visit_type make_visit(int unsigned cyl);
      visit_type v;
      v = '0;
      v.cylinder = cyl[CYL_W-1:0];
      v.dropped = overflow;
      return v;
   endfunction

   // Stores one request; the marked one turns the held batch into its C-SCAN visit order.
   function automatic void take_request(logic [CYL_W-1:0] cyl, logic last);
      logic [CYL_W-1:0] order [MAX_REQ];
      visit_type        batch [MAX_REQ + 2];
      logic [CYL_W-1:0] v;
      int               n, i, j, split, k;
      int unsigned      top, pos, total;
      if (held_count < MAX_REQ) begin
         held[held_count] = cyl;
         held_count++;
      end else begin
         overflow = 1'b1;
      end
      if (!last) return;
      n = held_count;
      for (i = 0; i < n; i++) order[i] = held[i];
      for (i = 1; i < n; i++) begin
         v = order[i];
         j = i;
         while (j > 0 && order[j-1] > v) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end
      top = top_of(geometry.disk_cylinders);
      pos = geometry.start_head;
      split = n;
      for (i = 0; i < n; i++)
         if (order[i] > pos && split == n) split = i;
      total = 0;
      k = 0;
      if (geometry.sweep_right) begin
         for (i = split; i < n; i++) begin
            total = add_travel(total, travel(order[i], pos));
            pos = order[i];
            batch[k++] = make_visit(pos);
         end
         total = add_travel(total, travel(top, pos));
         batch[k++] = make_visit(top);
         // The wrap from the top back to cylinder zero counts as travel.
         total = add_travel(total, top);
         pos = 0;
         batch[k++] = make_visit(0);
         for (i = 0; i < split; i++) begin
            total = add_travel(total, travel(order[i], pos));
            pos = order[i];
            batch[k++] = make_visit(pos);
         end
      end else begin
         for (i = split; i > 0; i--) begin
            total = add_travel(total, travel(order[i-1], pos));
            pos = order[i-1];
            batch[k++] = make_visit(pos);
         end
         total = add_travel(total, pos);
         batch[k++] = make_visit(0);
         total = add_travel(total, top);
         pos = top;
         batch[k++] = make_visit(top);
         for (i = n; i > split; i--) begin
            total = add_travel(total, travel(order[i-1], pos));
            pos = order[i-1];
            batch[k++] = make_visit(pos);
         end
      end
      batch[k-1].movement = total[TOTAL_W-1:0];
      batch[k-1].final_visit = 1'b1;
      for (i = 0; i < k; i++) pending_visits.push_back(batch[i]);
      held_count = 0;
      overflow = 1'b0;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_visits.size() == 0) begin
            $display("%0t: unexpected visit cyl %0d total %0d dropped %0b last %0b", $time,
                     rsp_visit_cylinder, rsp_total_movement, rsp_dropped, rsp_last_visit);
            error_count++;
         end else begin
            due_visit = pending_visits.pop_front();
            if ({rsp_visit_cylinder, rsp_total_movement, rsp_dropped, rsp_last_visit}
                !== due_visit) begin
               $display("%0t: expected cyl %0d total %0d dropped %0b last %0b", $time,
                        due_visit.cylinder, due_visit.movement, due_visit.dropped,
                        due_visit.final_visit);
               $display("%0t: actual   cyl %0d total %0d dropped %0b last %0b", $time,
                        rsp_visit_cylinder, rsp_total_movement, rsp_dropped, rsp_last_visit);
               error_count++;
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cylinder <= cyl;
      req_last_request <= last;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      take_request(cyl, last);
   endtask

   // Leaves the block idle: all visits in and the scheduler finished.
   task automatic settle;
      start <= 1'b0;
      while (pending_visits.size() != 0) @(posedge clock);
      repeat (LINGER) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] index, input logic [DISK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_DISK_CYLINDERS: geometry.disk_cylinders = data;
         CSR_START_HEAD:     geometry.start_head = data[CYL_W-1:0];
         CSR_SWEEP_RIGHT:    geometry.sweep_right = data[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [DISK_W-1:0] disk, input logic [DISK_W-1:0] head,
                               input logic [DISK_W-1:0] sweep);
      csr_beat(CSR_DISK_CYLINDERS, disk);
      csr_beat(CSR_START_HEAD, head);
      csr_beat(CSR_SWEEP_RIGHT, sweep);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CYL_W-1:0] pick_cylinder();
      int unsigned top;
      int          r;
      top = top_of(geometry.disk_cylinders);
      r = $urandom_range(0, 9);
      if (r == 0) return CYL_W'($urandom);
      if (r == 1) return geometry.start_head;
      if (r == 2) return ($urandom_range(0, 1) == 1) ? CYL_W'(top) : '0;
      return CYL_W'($urandom_range(0, top));
   endfunction

   task automatic test_reset_defaults;
      send_request(16'd120, 1'b0);
      send_request(16'd0, 1'b0);
      send_request(16'd199, 1'b1);
      send_request(16'd65535, 1'b1);
   endtask

   task automatic test_sweep_right;
      settle();
      set_geometry(17'd200, 17'd53, 17'd1);
      send_request(16'd98, 1'b0);
      send_request(16'd183, 1'b0);
      send_request(16'd37, 1'b0);
      send_request(16'd53, 1'b1);
      // Nothing above the head: the upward leg only runs to the top.
      send_request(16'd10, 1'b0);
      send_request(16'd53, 1'b1);
   endtask

   task automatic test_sweep_left;
      settle();
      set_geometry(17'd200, 17'd53, 17'd0);
      send_request(16'd98, 1'b0);
      send_request(16'd14, 1'b0);
      send_request(16'd53, 1'b1);
      // Nothing at or below the head: travel to cylinder zero counts from the head.
      send_request(16'd120, 1'b0);
      send_request(16'd180, 1'b1);
   endtask

   task automatic test_disk_extremes;
      settle();
      csr_beat(CSR_SPARE, 17'h1FFFF);
      set_geometry(17'd65536, 17'h1FFFF, 17'd1);
      send_request(16'd0, 1'b0);
      send_request(16'd65535, 1'b1);
      settle();
      set_geometry(17'd0, 17'd0, 17'd0);
      send_request(16'd5, 1'b1);
      settle();
      set_geometry(17'h1FFFF, 17'd40000, 17'd0);
      send_request(16'd65535, 1'b1);
      settle();
      set_geometry(17'd1, 17'd0, 17'd1);
      send_request(16'd0, 1'b1);
      settle();
      // Head and one of the two requests beyond the top of a small disk.
      set_geometry(17'd100, 17'd60000, 17'd1);
      send_request(16'd70, 1'b0);
      send_request(16'd30000, 1'b1);
   endtask

   task automatic test_random_batches;
      logic [DISK_W-1:0] disk;
      logic [DISK_W-1:0] head;
      int                phase, phase_items, size, i;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         settle();
         case ($urandom_range(0, 9))
            0: disk = 17'd1;
            1: disk = 17'd65536;
            2: disk = 17'd0;
            3: disk = 17'h1FFFF;
            4, 5: disk = 17'd200;
            default: disk = DISK_W'($urandom_range(2, 65536));
         endcase
         if ($urandom_range(0, 9) == 0) head = DISK_W'($urandom);
         else head = DISK_W'($urandom_range(0, top_of(disk)));
         set_geometry(disk, head, DISK_W'($urandom));
         steady = ($urandom_range(0, 3) == 0);
         phase_items = 0;
         while (phase_items < 45 && items_sent < ITEM_TARGET) begin
            // Every third phase opens with a batch that overruns the store.
            if (phase % 3 == 1 && phase_items == 0) size = $urandom_range(MAX_REQ + 1, MAX_REQ + 4);
            else begin
               case ($urandom_range(0, 9))
                  0, 1: size = $urandom_range(9, MAX_REQ);
                  2: size = ($urandom_range(0, 1) == 1) ? MAX_REQ : $urandom_range(1, 8);
                  default: size = $urandom_range(1, 8);
               endcase
            end
            for (i = 0; i < size; i++) send_request(pick_cylinder(), i == size - 1);
            phase_items += size;
         end
         phase++;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_sweep_right();
      test_sweep_left();
      test_disk_extremes();
      test_random_batches();
      settle();
      if (error_count == 0) begin
         $display("cscan_disk_scheduler_top: match");
      end else begin
         $display("cscan_disk_scheduler_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout with %0d visits outstanding", $time, pending_visits.size());
      $display("cscan_disk_scheduler_top: mismatch");
      $finish;
   end

endmodule

// File: cscan_disk_scheduler_top.f
rtl/cscan_pkg.sv
rtl/cscan_ctrl.sv
rtl/cscan_datapath.sv
rtl/cscan_disk_scheduler_top.sv
verif/testbench.sv
